// ===== design/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the set-associative lru tag store
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W = 64;
    localparam int CMD_W  = 2;

    // default geometry, handed to the top level parameters
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_STAMP_WIDTH  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_CFG_W  = 3;
    localparam int OFF_CFG_W  = 6;
    localparam int WAYS_CFG_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic hit;
        logic miss;
        logic eviction;
        logic modify_hit;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request and read the set row
        logic commit;   // resolve lookup, write the row back, emit the result
    } t_dp_cmd;

endpackage

// ===== design/set_assoc_cache_lru_tags_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_top
// set-associative cache tag store with true lru replacement by stamps
// ----------------------------------------------------------------------------
//  channel   | signals                                   | beat taken when
//  ----------+-------------------------------------------+-----------------------
//  request   | start, busy, i_req (command, address)     | start & !busy
//  result    | o_done, o_rsp (hit, miss, eviction, ...)  | every cycle o_done is 1
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | i_cfg_valid & o_cfg_ready
//            | i_cfg_data                                |
//
//  in an access the accept edge reads the set row from the row
//  memory, the next cycle compares all ways, picks the victim and writes the
//  row back, and the result beat shows in the cycle after that
//  busy holds off a new request until the lookup of the last one is done
//  reset is synchronous and needs no clearing pass: per-set row valid flops
//  make never-written sets read as all lines invalid
//  the result cannot be stalled; each beat is held for exactly one cycle
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_top #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = sacl_pkg::DEF_STAMP_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             start,
    output logic                             busy,
    input  sacl_pkg::t_req                   i_req,
    // result channel
    output logic                             o_done,
    output sacl_pkg::t_rsp                   o_rsp,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sacl_pkg::*;

    // configuration registers
    logic [SET_CFG_W-1:0]  r_set_bits;
    logic [OFF_CFG_W-1:0]  r_offset_bits;
    logic [WAYS_CFG_W-1:0] r_ways;

    t_dp_cmd w_cmd;

    // users must write only while idle, not checked here; port never pushes back
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_offset_bits <= '0;
            r_ways        <= WAYS_CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SET_BITS:    r_set_bits    <= i_cfg_data[SET_CFG_W-1:0];
                REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFF_CFG_W-1:0];
                REG_WAYS:        r_ways        <= i_cfg_data[WAYS_CFG_W-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // sequencer: idle -> lookup -> idle
    sacl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // row memory, compare, victim choice and result register
    sacl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_WIDTH  (STAMP_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_req             (i_req),
        .i_cfg_set_bits    (r_set_bits),
        .i_cfg_offset_bits (r_offset_bits),
        .i_cfg_ways        (r_ways),
        .o_done            (o_done),
        .o_rsp             (o_rsp)
    );

endmodule

// ===== design/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// access sequencer: accept a request, then the lookup/commit cycle
// ----------------------------------------------------------------------------
module sacl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output sacl_pkg::t_dp_cmd o_cmd
);
    import sacl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_commit;
    logic   w_capture;

    assign w_capture     = i_start & ~r_busy;
    assign o_busy        = r_busy;
    assign o_cmd.capture = w_capture;
    assign o_cmd.commit  = r_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_commit <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_capture) begin
                        r_state  <= ST_LOOKUP;
                        r_busy   <= 1'b1;
                        r_commit <= 1'b1;
                    end
                end
                ST_LOOKUP: begin
                    r_state  <= ST_IDLE;
                    r_busy   <= 1'b0;
                    r_commit <= 1'b0;
                end
                default: begin
                    r_state  <= ST_IDLE;
                    r_busy   <= 1'b0;
                    r_commit <= 1'b0;
                end
            endcase
        end
    end

    a_capture_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |=> (r_commit && r_state == ST_LOOKUP))
        else $error("accepted beat not followed by a commit cycle");

    a_single_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOKUP |=> (r_state == ST_IDLE && !r_commit))
        else $error("lookup lasted more than one cycle");

    a_commit_from_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commit |-> $past(w_capture))
        else $error("commit without a preceding capture");

endmodule

// ===== design/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// tag store datapath: address split, set row memory, hit search,
// lru victim tree, row write-back and result register
// ----------------------------------------------------------------------------
module sacl_dp #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = sacl_pkg::DEF_STAMP_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sacl_pkg::t_dp_cmd                i_cmd,
    input  sacl_pkg::t_req                   i_req,
    input  logic [sacl_pkg::SET_CFG_W-1:0]   i_cfg_set_bits,
    input  logic [sacl_pkg::OFF_CFG_W-1:0]   i_cfg_offset_bits,
    input  logic [sacl_pkg::WAYS_CFG_W-1:0]  i_cfg_ways,
    output logic                             o_done,
    output sacl_pkg::t_rsp                   o_rsp
);
    import sacl_pkg::*;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int LVLS     = $clog2(MAX_WAYS);
    localparam int PAD      = 1 << LVLS;
    localparam int KEY_W    = STAMP_WIDTH + 1;
    localparam int SB_W     = 4;
    localparam int SH_W     = 7;

    // set row memory, one row per set, all ways side by side
    logic [MAX_WAYS-1:0]                  r_mem_valid [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      r_mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] r_mem_stamp [NUM_SETS];
    logic [NUM_SETS-1:0]                  r_row_vld;

    logic [SET_W-1:0]                     r_set;
    logic [ADDR_W-1:0]                    r_tag;
    logic                                 r_modify;
    logic                                 r_rd_live;
    logic [MAX_WAYS-1:0]                  r_rd_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] r_rd_stamp;
    logic [STAMP_WIDTH-1:0]               r_counter;
    logic                                 r_done;
    t_rsp                                 r_rsp;

    // address split
    logic [SB_W-1:0]   w_sbits;
    logic [SET_W-1:0]  w_set_mask;
    logic [ADDR_W-1:0] w_addr_sh;
    logic [SET_W-1:0]  w_set_sel;
    logic [SH_W-1:0]   w_tag_sh;
    logic [ADDR_W-1:0] w_tag_sel;

    always_comb begin
        w_sbits    = (int'(i_cfg_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                           : SB_W'(i_cfg_set_bits);
        w_set_mask = ~({SET_W{1'b1}} << w_sbits);
        w_addr_sh  = i_req.address >> i_cfg_offset_bits;
        w_set_sel  = w_addr_sh[SET_W-1:0] & w_set_mask;
        w_tag_sh   = SH_W'(i_cfg_offset_bits) + SH_W'(w_sbits);
        w_tag_sel  = (w_tag_sh >= SH_W'(ADDR_W)) ? '0 : (i_req.address >> w_tag_sh);
    end

    // lookup
    logic [WCNT_W-1:0]                    w_ways_eff;
    logic [MAX_WAYS-1:0]                  w_used;
    logic [MAX_WAYS-1:0]                  w_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      w_tags;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] w_stamps;
    logic [MAX_WAYS-1:0]                  w_match;
    logic [MAX_WAYS-1:0]                  w_free;
    logic                                 w_hit;
    logic                                 w_any_free;
    logic [WAY_W-1:0]                     w_hit_way;
    logic [WAY_W-1:0]                     w_free_way;
    logic [WAY_W-1:0]                     w_victim;
    logic [KEY_W-1:0]                     w_key [LVLS+1][PAD];
    logic [WAY_W-1:0]                     w_idx [LVLS+1][PAD];
    logic [MAX_WAYS-1:0]                  n_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      n_tag;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] n_stamp;

    always_comb begin
        if (i_cfg_ways == '0) begin
            w_ways_eff = WCNT_W'(1);
        end else if (int'(i_cfg_ways) > MAX_WAYS) begin
            w_ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            w_ways_eff = WCNT_W'(i_cfg_ways);
        end

        // a row never written since reset reads as all invalid
        w_valid  = r_rd_live ? r_rd_valid : '0;
        w_tags   = r_rd_live ? r_rd_tag   : '0;
        w_stamps = r_rd_live ? r_rd_stamp : '0;

        for (int w = 0; w < MAX_WAYS; w++) begin
            w_used[w]  = w_ways_eff > WCNT_W'(w);
            w_match[w] = w_used[w] & w_valid[w] & (w_tags[w] == r_tag);
            w_free[w]  = w_used[w] & ~w_valid[w];
        end
        w_hit      = |w_match;
        w_any_free = |w_free;

        // lowest matching way, lowest free way
        w_hit_way  = '0;
        w_free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) w_hit_way  = WAY_W'(w);
            if (w_free[w])  w_free_way = WAY_W'(w);
        end

        // oldest stamp, unused ways pushed to the top by the key msb
        for (int p = 0; p < PAD; p++) begin
            if (p < MAX_WAYS) begin
                w_key[0][p] = {~w_used[p], w_stamps[p]};
            end else begin
                w_key[0][p] = '1;
            end
            w_idx[0][p] = WAY_W'(p);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int p = 0; p < (PAD >> (l + 1)); p++) begin
                if (w_key[l][2*p+1] < w_key[l][2*p]) begin
                    w_key[l+1][p] = w_key[l][2*p+1];
                    w_idx[l+1][p] = w_idx[l][2*p+1];
                end else begin
                    w_key[l+1][p] = w_key[l][2*p];
                    w_idx[l+1][p] = w_idx[l][2*p];
                end
            end
            for (int p = (PAD >> (l + 1)); p < PAD; p++) begin
                w_key[l+1][p] = '1;
                w_idx[l+1][p] = '0;
            end
        end

        if (w_hit) begin
            w_victim = w_hit_way;
        end else if (w_any_free) begin
            w_victim = w_free_way;
        end else begin
            w_victim = w_idx[LVLS][0];
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w_victim == WAY_W'(w)) begin
                n_valid[w] = 1'b1;
                n_tag[w]   = r_tag;
                n_stamp[w] = r_counter;
            end else begin
                n_valid[w] = w_valid[w];
                n_tag[w]   = w_tags[w];
                n_stamp[w] = w_stamps[w];
            end
        end
    end

    // row read on capture, row write on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_set      <= w_set_sel;
            r_tag      <= w_tag_sel;
            r_modify   <= (i_req.command == CMD_MODIFY);
            r_rd_live  <= r_row_vld[w_set_sel];
            r_rd_valid <= r_mem_valid[w_set_sel];
            r_rd_tag   <= r_mem_tag[w_set_sel];
            r_rd_stamp <= r_mem_stamp[w_set_sel];
        end
        if (i_cmd.commit) begin
            r_mem_valid[r_set] <= n_valid;
            r_mem_tag[r_set]   <= n_tag;
            r_mem_stamp[r_set] <= n_stamp;
            r_rsp.hit          <= w_hit;
            r_rsp.miss         <= ~w_hit;
            r_rsp.eviction     <= ~w_hit & ~w_any_free;
            r_rsp.modify_hit   <= r_modify;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_counter <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_row_vld[r_set] <= 1'b1;
                r_counter        <= r_counter + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> o_done)
        else $error("commit did not produce a result beat");

    a_no_stray_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> !o_done)
        else $error("result beat without a commit");

    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($onehot({o_rsp.hit, o_rsp.miss}) && !(o_rsp.hit && o_rsp.eviction)))
        else $error("inconsistent hit, miss and eviction flags");

    a_stamp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_counter == STAMP_WIDTH'($past(r_counter) + 1'b1))
        else $error("stamp counter did not advance on commit");

endmodule

// ===== tb/sv/tb_set_assoc_cache_lru_tags_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_tags_top
// self-checking bench for the set-associative lru tag store: a class keeps
// its own copy of the lines, stamps and registers, predicts hit, miss,
// eviction and modify flags for each accepted access and checks every
// result beat in order; directed corner accesses come first, then random
// phases with a new geometry each, built mostly from a small pool of tags
// and sets so that hits, fills and evictions all happen
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_tags_top;
    import sacl_pkg::*;

    // access kinds besides the package's modify code
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, acts as a load

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int NUM_LINES       = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
    localparam int QUIET_LIMIT     = 2000;   // cycles with no beat of any kind
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 130;

    // ------------------------------------------------------------------------
    // tag store model and in-order outcome check
    // ------------------------------------------------------------------------
    class tag_store_checker;
        bit                         line_valid [NUM_LINES];
        logic [ADDR_W-1:0]          line_tag   [NUM_LINES];
        logic [DEF_STAMP_WIDTH-1:0] line_stamp [NUM_LINES];
        logic [DEF_STAMP_WIDTH-1:0] access_count;
        int unsigned                set_bits_reg;
        int unsigned                offset_bits_reg;
        int unsigned                ways_reg;
        t_rsp                       pending_outcomes[$];
        int                         errors;

        function new();
            foreach (line_valid[i]) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            access_count    = '0;
            set_bits_reg    = 0;
            offset_bits_reg = 0;
            ways_reg        = 1;
            errors          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SET_BITS:    set_bits_reg    = data[SET_CFG_W-1:0];
                REG_OFFSET_BITS: offset_bits_reg = data[OFF_CFG_W-1:0];
                REG_WAYS:        ways_reg        = data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // look the access up, update the set and queue the outcome it gives
        function void note_access(t_req r);
            int unsigned       sb;
            int unsigned       ob;
            int unsigned       ways;
            int unsigned       set;
            int unsigned       base;
            int unsigned       victim;
            logic [ADDR_W-1:0] tag;
            bit                found;
            bit                took_invalid;
            t_rsp              outcome;

            sb   = (set_bits_reg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_bits_reg;
            ob   = offset_bits_reg;
            ways = (ways_reg == 0) ? 1 : ((ways_reg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_reg);
            set  = 32'((r.address >> ob) & ((64'd1 << sb) - 64'd1));
            tag  = (ob + sb >= ADDR_W) ? '0 : (r.address >> (ob + sb));
            base = set * DEF_MAX_WAYS;

            outcome      = '0;
            found        = 1'b0;
            took_invalid = 1'b0;
            victim       = 0;

            for (int w = 0; w < ways && !found; w++) begin
                if (line_valid[base + w] && line_tag[base + w] == tag) begin
                    line_stamp[base + w] = access_count;
                    access_count++;
                    outcome.hit = 1'b1;
                    found = 1'b1;
                end
            end

            if (!found) begin
                // first invalid way, else the oldest stamp with the lowest way on a tie
                for (int w = 0; w < ways && !took_invalid; w++) begin
                    if (!line_valid[base + w]) begin
                        victim = w;
                        took_invalid = 1'b1;
                    end else if (line_stamp[base + w] < line_stamp[base + victim]) begin
                        victim = w;
                    end
                end
                outcome.miss     = 1'b1;
                outcome.eviction = !took_invalid && line_valid[base + victim];
                line_valid[base + victim] = 1'b1;
                line_tag[base + victim]   = tag;
                line_stamp[base + victim] = access_count;
                access_count++;
            end

            outcome.modify_hit = (r.command == CMD_MODIFY);
            pending_outcomes.push_back(outcome);
        endfunction

        function void check_outcome(t_rsp got);
            t_rsp want;
            if (pending_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, got h=%b m=%b e=%b mod=%b",
                         $time, got.hit, got.miss, got.eviction, got.modify_hit);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.hit !== want.hit || got.miss !== want.miss ||
                    got.eviction !== want.eviction || got.modify_hit !== want.modify_hit) begin
                    errors++;
                    $display("%0t: mismatch, expected h=%b m=%b e=%b mod=%b, got h=%b m=%b e=%b mod=%b",
                             $time, want.hit, want.miss, want.eviction, want.modify_hit,
                             got.hit, got.miss, got.eviction, got.modify_hit);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tag_store_checker tag_model;
    int               quiet_cycles;

    set_assoc_cache_lru_tags_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // every result beat is checked at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tag_model.check_outcome(o_rsp);
    end

    // watchdog: any request, result or config beat counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("set_assoc_cache_lru_tags_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers: inputs move on the falling edge, handshakes are seen on the rising
    // ------------------------------------------------------------------------

    // optional idle cycles counted once the block is free, then one request
    // held until the block takes it; start is left high so back-to-back
    // requests keep it up
    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                               input int gap);
        t_req r;
        r.command = cmd;
        r.address = addr;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            while (busy)
                @(negedge i_clk);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        tag_model.note_access(r);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tag_model.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] set_data,
                             input logic [CFG_DATA_W-1:0] off_data,
                             input logic [CFG_DATA_W-1:0] ways_data);
        write_cfg(REG_SET_BITS, set_data);
        write_cfg(REG_OFFSET_BITS, off_data);
        write_cfg(REG_WAYS, ways_data);
    endtask

    // stop requesting, let every outstanding beat come back plus a little slack
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tag_model.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] set_raw;
        logic [CFG_DATA_W-1:0] off_raw;
        logic [CFG_DATA_W-1:0] ways_raw;
        logic [ADDR_W-1:0]     tag_pool [DEF_MAX_WAYS + 2];
        logic [ADDR_W-1:0]     addr;
        logic [ADDR_W-1:0]     set_sel;
        int unsigned           sb_eff;
        int unsigned           off_eff;
        int unsigned           ways_eff;
        int unsigned           pool_n;
        int unsigned           set_base;
        int                    idle_pct;
        int                    gap;

        tag_model   = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // four sets of 16-byte blocks, two ways: offset [3:0], set [5:4], tag above
        configure(6'd2, 6'd4, 6'd2);
        send_access(CMD_LOAD,   64'h0, 0);                   // cold miss into way 0
        send_access(CMD_LOAD,   64'hF, 0);                   // same block, hit
        send_access(CMD_STORE,  64'h40, 1);                  // second tag fills way 1
        send_access(CMD_MODIFY, 64'h80, 0);                  // set full, oldest way evicted
        send_access(CMD_LOAD,   64'h0, 2);                   // evicted tag misses again
        send_access(CMD_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, 0); // spare code behaves as load
        send_access(CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(CMD_STORE,  64'h8000_0000_0000_0000, 1);
        send_access(CMD_MODIFY, 64'h5555_5555_5555_5555, 0);
        send_access(CMD_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 0);
        drain();

        // set bits beyond the maximum saturate, zero ways acts as one way,
        // and offset plus set bits past 64 leaves a tag of zero
        configure(6'd7, 6'd63, 6'd0);
        send_access(CMD_LOAD,   64'h0, 0);
        send_access(CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(CMD_LOAD,   64'h7FFF_FFFF_FFFF_FFFF, 1);
        send_access(CMD_MODIFY, 64'h1, 0);
        drain();

        // offset plus set bits exactly 64, ways above the maximum saturate,
        // and a write to an index with no register must change nothing
        configure(6'd6, 6'd58, 6'd12);
        write_cfg(REG_UNUSED, 6'h3F);
        send_access(CMD_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_access(CMD_LOAD,   64'h0400_0000_0000_0000, 0);
        send_access(CMD_MODIFY, 64'h0, 2);
        drain();

        // narrow back to one way: stale lines in the other ways must be ignored
        configure(6'h3F, 6'd0, 6'h31);
        send_access(CMD_LOAD,  64'h1234_5678_9ABC_DEF0, 0);
        send_access(CMD_LOAD,  64'h1234_5678_9ABC_DEF0, 0);
        send_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFC0, 1);
        drain();

        // random phases, each with its own geometry; sender idles 15% of the
        // free cycles first, then 66%, then not at all
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p < 4) ? 15 : ((p < 8) ? 66 : 0);
            case (p)
                0: begin set_raw = 6'd6; off_raw = 6'd6;  ways_raw = 6'd8;  end
                1: begin set_raw = 6'd0; off_raw = 6'd0;  ways_raw = 6'd1;  end
                5: begin set_raw = 6'd6; off_raw = 6'd63; ways_raw = 6'd15; end
                9: begin set_raw = 6'd7; off_raw = 6'd0;  ways_raw = 6'd8;  end
                default: begin
                    set_raw = $urandom_range(0, 63);
                    case ($urandom_range(0, 9))
                        7:       off_raw = 6'd63;
                        8, 9:    off_raw = $urandom_range(0, 63);
                        default: off_raw = $urandom_range(0, 8);
                    endcase
                    ways_raw = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                           : $urandom_range(0, 63);
                end
            endcase
            configure(set_raw, off_raw, ways_raw);

            // effective geometry, used only to aim addresses at a few sets
            sb_eff   = (set_raw[SET_CFG_W-1:0] > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS
                                                                   : set_raw[SET_CFG_W-1:0];
            off_eff  = off_raw;
            ways_eff = ways_raw[WAYS_CFG_W-1:0];
            if (ways_eff == 0)
                ways_eff = 1;
            if (ways_eff > DEF_MAX_WAYS)
                ways_eff = DEF_MAX_WAYS;

            // a couple of tags more than the ways so that sets overflow
            pool_n = ways_eff + 2;
            for (int k = 0; k < pool_n; k++)
                tag_pool[k] = {$urandom, $urandom};
            set_base = $urandom;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    set_sel = (set_base + $urandom_range(0, 2)) & ((64'd1 << sb_eff) - 64'd1);
                    addr    = (tag_pool[$urandom_range(0, pool_n - 1)] << (off_eff + sb_eff))
                            | (set_sel << off_eff)
                            | ({$urandom, $urandom} & ((64'd1 << off_eff) - 64'd1));
                end else begin
                    addr = {$urandom, $urandom};
                end
                // each free cycle idles with the phase's odds
                gap = 0;
                while ($urandom_range(0, 99) < idle_pct)
                    gap++;
                send_access(CMD_W'($urandom_range(0, 3)), addr, gap);
            end
            drain();
        end

        // all beats are back; a few more cycles to catch any stray result
        repeat (8) @(posedge i_clk);
        if (tag_model.errors == 0 && tag_model.pending_outcomes.size() == 0) begin
            $display("set_assoc_cache_lru_tags_top verification clean");
        end else begin
            $display("set_assoc_cache_lru_tags_top verification failed");
        end
        $finish;
    end

endmodule
